>>> design/sliding_window_min_max_mean_macros.svh
// Assertion macros shared by the sliding-window statistics RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_MEAN_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> design/swm_pkg.sv
// Shared constants for the sliding-window min/max/mean block.
// No dependencies.
package swm_pkg;

  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned WINDOW_LEN_DEF = 64;

endpackage

>>> design/swm_intf.sv
// Stream interfaces for sample words in and statistics words out.
// Depends on swm_pkg.
interface swm_sample_if;
  import swm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_us;

  modport source (output valid, output sample_us, input ready);
  modport sink   (input valid, input sample_us, output ready);
endinterface

interface swm_result_if;
  import swm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] window_min;
  logic [SAMPLE_W-1:0] window_max;
  logic [SAMPLE_W-1:0] window_mean;

  modport source (output valid, output window_min, output window_max, output window_mean,
                  input ready);
  modport sink   (input valid, input window_min, input window_max, input window_mean,
                  output ready);
endinterface

>>> design/swm_cell.sv
// One slot of the sample ring: a loadable register fed by its neighbor.
// Depends on swm_pkg.
module swm_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [swm_pkg::SAMPLE_W-1:0] d_i,
  output logic [swm_pkg::SAMPLE_W-1:0] q_o
);
  import swm_pkg::*;

  logic [SAMPLE_W-1:0] val_q;

  // window starts zero-filled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

>>> design/swm_div.sv
// Division by a constant through reciprocal multiplication, one reciprocal digit at a time.
// Depends on swm_pkg.
module swm_div #(
  parameter int unsigned DIVISOR    = swm_pkg::WINDOW_LEN_DEF,
  parameter int unsigned DIVIDEND_W = swm_pkg::SAMPLE_W + $clog2(swm_pkg::WINDOW_LEN_DEF)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DIVIDEND_W-1:0]        dividend_i,
  output logic                         idle_o,
  output logic [swm_pkg::SAMPLE_W-1:0] quotient_o
);
  import swm_pkg::*;

  // floor(x / D) == (x * ceil(2^SHIFT / D)) >> SHIFT for every x below 2^DIVIDEND_W
  localparam int unsigned SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int unsigned DIG_W   = 12;
  localparam int unsigned STEPS_N = (DIVIDEND_W + DIG_W) / DIG_W;
  localparam int unsigned RCP_W   = STEPS_N * DIG_W;
  localparam int unsigned PROD_W  = DIVIDEND_W + RCP_W;
  localparam int unsigned CW      = $clog2(STEPS_N + 1);
  localparam logic [63:0] RCP_WIDE =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_WIDE);
  localparam logic [CW-1:0]    STEPS = CW'(STEPS_N);

  logic                        busy_q, busy_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0]       num_q, num_d;
  logic [RCP_W-1:0]            rcp_q, rcp_d;
  logic [PROD_W-1:0]           prod_q, prod_d;
  logic [DIG_W-1:0]            digit;
  logic [DIVIDEND_W+DIG_W-1:0] part;

  always_comb begin
    digit  = rcp_q[RCP_W-1 -: DIG_W];
    part   = {{DIG_W{1'b0}}, num_q} * {{DIVIDEND_W{1'b0}}, digit};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rcp_d  = rcp_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEPS;
      num_d  = dividend_i;
      rcp_d  = RECIP;
      prod_d = '0;
    end else if (busy_q) begin
      // one reciprocal digit per cycle, most significant first
      prod_d = {prod_q[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + {{(RCP_W-DIG_W){1'b0}}, part};
      rcp_d  = {rcp_q[RCP_W-DIG_W-1:0], {DIG_W{1'b0}}};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rcp_q  <= rcp_d;
    prod_q <= prod_d;
  end

  assign idle_o     = ~busy_q;
  // total never exceeds DIVISOR * max sample, so the quotient fits
  assign quotient_o = prod_q[SHIFT +: SAMPLE_W];

endmodule

>>> design/sliding_window_min_max_mean.sv
// Sliding-window latency statistics: minimum, maximum and mean of the last WINDOW_LEN samples.
// Depends on swm_pkg, swm_intf, swm_cell, swm_div and the assertion macro header.
//
// One sample word in gives one statistics word out. The window is a ring of
// WINDOW_LEN cells, zero after reset, so results before the window has filled
// count those zeros in the minimum and the mean. On accept the new sample
// shifts into the ring and the oldest one drops off the far end, updating a
// running total. The ring then rotates one full turn, one cell per cycle,
// while min/max are taken from the cell at its tail; after WINDOW_LEN steps
// every cell is back in place. In parallel the mean floor(total / WINDOW_LEN)
// is formed by multiplying with a constant reciprocal, 12 bits of it per
// cycle, well inside the rotation. After the rotation the block sits in its
// wait state until the divider is idle and the output register is free,
// then loads the result register and returns to idle; it takes no new
// sample while an item is in flight. The next sample is taken as soon as the
// block is back in idle, even while the previous result still sits in the
// output register waiting for ready; a result that cannot leave holds the
// block in its wait state and stalls the input.
`include "sliding_window_min_max_mean_macros.svh"

module sliding_window_min_max_mean #(
  parameter int unsigned WINDOW_LEN = swm_pkg::WINDOW_LEN_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swm_sample_if.sink   sample_i,
  swm_result_if.source result_o
);
  import swm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN);
  localparam int unsigned TOT_W = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(WINDOW_LEN - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [TOT_W-1:0]    total_q, total_d;
  logic [SAMPLE_W-1:0] min_q, max_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_min_q, out_max_q, out_mean_q;

  logic                in_fire;
  logic                scanning;
  logic                out_free;
  logic                load_out;
  logic                div_idle;
  logic [SAMPLE_W-1:0] quotient;
  logic [SAMPLE_W-1:0] tail;

  logic [SAMPLE_W-1:0] cell_q [WINDOW_LEN];
  logic [SAMPLE_W-1:0] cell_d [WINDOW_LEN];

  assign sample_i.ready = (state_q == S_IDLE);
  assign in_fire        = sample_i.valid & sample_i.ready;
  assign scanning       = (state_q == S_SCAN);
  assign tail           = cell_q[WINDOW_LEN-1];
  assign out_free       = ~out_valid_q | result_o.ready;
  assign load_out       = (state_q == S_WAIT) & div_idle & out_free;

  // new total: drop the oldest sample, add the new one
  assign total_d = total_q - TOT_W'(tail) + TOT_W'(sample_i.sample_us);

  // ring of cells: shift in a new sample, or rotate tail back to head
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_ring
    if (i == 0) begin : g_head
      assign cell_d[i] = scanning ? tail : sample_i.sample_us;
    end else begin : g_body
      assign cell_d[i] = cell_q[i-1];
    end
    swm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (in_fire | scanning),
      .d_i    (cell_d[i]),
      .q_o    (cell_q[i])
    );
  end

  swm_div #(
    .DIVISOR    (WINDOW_LEN),
    .DIVIDEND_W (TOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .dividend_i (total_d),
    .idle_o     (div_idle),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      min_q       <= '1;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      out_min_q   <= '0;
      out_max_q   <= '0;
      out_mean_q  <= '0;
    end else begin
      // a word leaving frees the register unless a new one lands the same edge
      if (out_valid_q && result_o.ready && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            total_q <= total_d;
            cnt_q   <= '0;
            min_q   <= '1;
            max_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail < min_q) min_q <= tail;
          if (tail > max_q) max_q <= tail;
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == LAST_CELL) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_min_q   <= min_q;
            out_max_q   <= max_q;
            out_mean_q  <= quotient;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.window_min  = out_min_q;
  assign result_o.window_max  = out_max_q;
  assign result_o.window_mean = out_mean_q;

  `SWM_ASSERT_NEXT(a_accept_starts_scan, in_fire, state_q == S_SCAN, "accept did not start scan")
  `SWM_ASSERT_NEXT(a_scan_ends, scanning && cnt_q == LAST_CELL, state_q == S_WAIT, "scan overran")
  `SWM_ASSERT_NOW(a_load_div_done, load_out, div_idle, "result loaded before divider done")
  `SWM_ASSERT_NOW(a_min_le_max, out_valid_q, out_min_q <= out_max_q, "window min above max")

endmodule

>>> test/sliding_window_min_max_mean_tb.sv
// Self-checking testbench for sliding_window_min_max_mean: sample words in, statistics words out.
// Depends on swm_pkg, the swm_sample_if / swm_result_if interfaces and the block itself.
// A local model of the 64-entry ring predicts min, max and truncated mean for every sample.
module sliding_window_min_max_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  // Window geometry of the default build.
  localparam int unsigned WIN      = WINDOW_LEN_DEF;
  localparam int unsigned TOTAL_W  = SAMPLE_W + $clog2(WIN);
  // Accept-to-result time: the ring rotation plus the result load.
  localparam int unsigned ITEM_LAT = WIN + 1;
  // Limit for the slowest legal run (long gaps on both sides for every
  // word plus the hold-off), with a wide margin.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYC    = 600;
  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned PRESSURE_ITEMS = 40;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] min_us;
    logic [SAMPLE_W-1:0] max_us;
    logic [SAMPLE_W-1:0] mean_us;
  } stats_t;

  // Shapes of random sample content.
  typedef enum int unsigned {
    KIND_FULL,    // uniform over the whole 24-bit range
    KIND_SMALL,   // near zero, keeps min pinned low
    KIND_TOP,     // near saturation, stresses the running total
    KIND_FLAT,    // one value repeated, window converges to it
    KIND_ONEHOT   // single set bit
  } sample_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  swm_sample_if sample_bus ();
  swm_result_if result_bus ();

  sliding_window_min_max_mean uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_bus.sink),
    .result_o (result_bus.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring model: same window and running total; slots are written in turn, not shifted.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ring_model [WIN];
  int unsigned         write_slot;
  logic [TOTAL_W-1:0]  window_sum;

  stats_t      stats_due [$];   // statistics still owed by the block
  int unsigned mismatch_cnt   = 0;
  int unsigned words_in       = 0;
  int unsigned words_out      = 0;
  int unsigned directed_cnt   = 0;
  int unsigned cycle_cnt      = 0;

  // Idle knobs, flipped by the tests.
  bit          sender_idle_en = 1'b1;
  bit          drain_stall_en = 1'b1;
  int unsigned hold_off_req   = 0;

  // Shift one sample into the ring and return the window statistics after it.
  function automatic stats_t window_stats_after(input logic [SAMPLE_W-1:0] sample);
    stats_t st;
    window_sum             = window_sum - ring_model[write_slot] + sample;
    ring_model[write_slot] = sample;
    write_slot             = (write_slot + 1) % WIN;
    st.min_us = ring_model[0];
    st.max_us = ring_model[0];
    for (int i = 1; i < WIN; i++) begin
      if (ring_model[i] < st.min_us) st.min_us = ring_model[i];
      if (ring_model[i] > st.max_us) st.max_us = ring_model[i];
    end
    // sum / WIN never exceeds the largest sample, so it fits 24 bits
    st.mean_us = SAMPLE_W'(window_sum / WIN);
    return st;
  endfunction

  // Mostly short idles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 15);
    return $urandom_range(30, 150);
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                 input logic [SAMPLE_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("[%0t] %s: expected %h, got %h (statistics word %0d)",
               $realtime, what, want, got, words_out);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, where the block's
  // outputs and our nonblocking drives still hold their pre-edge values.
  // The result side is handled first: a word leaving on the same edge as a
  // new sample entering always belongs to an earlier sample.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stats_t want;
    stats_t due;
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        words_out++;
        if (stats_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] statistics word with nothing pending: min %h max %h mean %h",
                     $realtime, result_bus.window_min, result_bus.window_max,
                     result_bus.window_mean);
        end else begin
          want = stats_due.pop_front();
          if (result_bus.window_min !== want.min_us)
            report_mismatch("window_min", want.min_us, result_bus.window_min);
          if (result_bus.window_max !== want.max_us)
            report_mismatch("window_max", want.max_us, result_bus.window_max);
          if (result_bus.window_mean !== want.mean_us)
            report_mismatch("window_mean", want.mean_us, result_bus.window_mean);
        end
      end
      if (sample_bus.valid && sample_bus.ready) begin
        words_in++;
        due       = window_stats_after(sample_bus.sample_us);
        stats_due = {stats_due, due};
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d statistics words outstanding",
               cycle_cnt, stats_due.size());
      $display("sliding_window_min_max_mean: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off on request that is
  // counted down here so the sender keeps offering words meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : drain_ctrl
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (!rst_ni) begin
        result_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (drain_stall_en && $urandom_range(0, 4) == 0) begin
        stall_left = pick_gap();
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side. Called just after a rising edge. valid is only lowered when
  // a gap follows, so back-to-back words never see a drop and rise in the
  // same step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = sender_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.sample_us <= value;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample(input sample_kind_e kind,
                                                        input logic [SAMPLE_W-1:0] flat);
    case (kind)
      KIND_SMALL:  return SAMPLE_W'($urandom_range(0, 255));
      KIND_TOP:    return SAMPLE_TOP - SAMPLE_W'($urandom_range(0, 255));
      KIND_FLAT:   return flat;
      KIND_ONEHOT: return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
      default:     return SAMPLE_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the window is all zeros: min stays zero and the mean
  // is diluted by the empty slots. Field extremes and bit patterns go in here.
  // (The sample port is exactly 24 bits, so there are no wider bits to drop.)
  task automatic test_early_window();
    logic [SAMPLE_W-1:0] pattern [12];
    pattern = '{24'hFFFFFF, 24'h000000, 24'h000001, 24'hFFFFFE,
                24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555,
                24'h00003F, 24'h000040, 24'hFFFFFF, 24'h000000};
    foreach (pattern[i]) begin
      send_sample(pattern[i]);
      directed_cnt++;
    end
  endtask

  // A full window of saturated samples: running total hits its ceiling and
  // the truncated mean must equal the max exactly; min climbs off zero once
  // the last empty slot is overwritten.
  task automatic test_saturated_window();
    sender_idle_en = 1'b0;
    repeat (WIN) send_sample(SAMPLE_TOP);
    sender_idle_en = 1'b1;
  endtask

  // Phases of shaped random content; some phases run with no idling at all.
  task automatic test_random_windows();
    int unsigned         sent;
    int unsigned         phase_len;
    sample_kind_e        kind;
    logic [SAMPLE_W-1:0] flat;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind           = sample_kind_e'($urandom_range(KIND_FULL, KIND_ONEHOT));
      flat           = SAMPLE_W'($urandom());
      phase_len      = $urandom_range(20, 70);
      sender_idle_en = ($urandom_range(0, 3) != 0);
      drain_stall_en = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        // full-range noise sprinkled into every phase
        if ($urandom_range(0, 7) == 0) send_sample(random_sample(KIND_FULL, flat));
        else                           send_sample(random_sample(kind, flat));
        sent++;
      end
    end
    sender_idle_en = 1'b1;
    drain_stall_en = 1'b1;
  endtask

  // Receiver goes quiet for a long stretch while samples keep coming; the
  // block must back up into its input and lose nothing.
  task automatic test_output_backpressure();
    sender_idle_en = 1'b0;
    drain_stall_en = 1'b0;
    hold_off_req   = HOLD_CYC;
    repeat (PRESSURE_ITEMS) send_sample(SAMPLE_W'($urandom()));
    sender_idle_en = 1'b1;
    drain_stall_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    sample_bus.valid     <= 1'b0;
    sample_bus.sample_us <= '0;
    foreach (ring_model[i]) ring_model[i] = '0;
    write_slot = 0;
    window_sum = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_early_window();
    test_saturated_window();
    test_random_windows();
    test_output_backpressure();

    sample_bus.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk_i);
    // anything extra the block might still push out
    repeat (ITEM_LAT + 20) @(posedge clk_i);

    $display("Covered %0d samples (%0d directed, one full saturated window), %0d ring wraps,",
             words_in, directed_cnt, words_in / WIN);
    $display("random stalls on both sides and a %0d-cycle output hold-off;",
             HOLD_CYC);
    $display("%0d words checked, %0d mismatches.", words_out, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("sliding_window_min_max_mean: match");
    end else begin
      $display("sliding_window_min_max_mean: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/swm_pkg.sv
design/swm_intf.sv
design/swm_cell.sv
design/swm_div.sv
design/sliding_window_min_max_mean.sv
test/sliding_window_min_max_mean_tb.sv
